// ===== hw/rtl/lrs_pkg.sv =====
// Shared types and codes for the link reconnect supervisor.
// Holds command codes, register indexes, the register file struct and the result struct.
package lrs_pkg;

	localparam int CMD_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam int NOW_W = 32;
	localparam int TALLY_W = 8;

	localparam logic [CMD_W-1:0] CMD_POLL        = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUSPEND_ON  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUSPEND_OFF = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ASSOCIATED  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ADDR_GOT    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DISCONNECT  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAILS_FALLBACK  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_KEEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_KICK    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STATION_RESTART = 3'd5;

	localparam logic [CFG_DATA_W-1:0] RETRY_INTERVAL_RST  = 32'd5000;
	localparam logic [CFG_DATA_W-1:0] ATTEMPT_TIMEOUT_RST = 32'd20000;
	localparam logic [TALLY_W-1:0]    FAILS_FALLBACK_RST  = 8'd3;
	localparam logic [CFG_DATA_W-1:0] FALLBACK_KEEP_RST   = 32'd60000;
	localparam logic [CFG_DATA_W-1:0] ADDRESS_KICK_RST    = 32'd7000;
	localparam logic [CFG_DATA_W-1:0] STATION_RESTART_RST = 32'd15000;

	localparam logic [TALLY_W-1:0] TALLY_MAX = 8'd255;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] retry_interval_ms;
		logic [CFG_DATA_W-1:0] attempt_timeout_ms;
		logic [TALLY_W-1:0]    fails_before_fallback;
		logic [CFG_DATA_W-1:0] fallback_keep_ms;
		logic [CFG_DATA_W-1:0] address_kick_ms;
		logic [CFG_DATA_W-1:0] station_restart_ms;
	} cfg_t;

	typedef struct packed {
		logic               begin_attempt;
		logic               restart_address;
		logic               restart_station;
		logic               start_fallback;
		logic               stop_fallback;
		logic               indicator_on;
		logic               attempt_active;
		logic [TALLY_W-1:0] failure_count;
	} result_t;

endpackage

// ===== hw/rtl/lrs_cfg_regs.sv =====
// Configuration register file of the link reconnect supervisor.
// Depends on lrs_pkg for register indexes, reset values and cfg_t.
module lrs_cfg_regs
	import lrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_interval_ms     <= RETRY_INTERVAL_RST;
			cfg_q.attempt_timeout_ms    <= ATTEMPT_TIMEOUT_RST;
			cfg_q.fails_before_fallback <= FAILS_FALLBACK_RST;
			cfg_q.fallback_keep_ms      <= FALLBACK_KEEP_RST;
			cfg_q.address_kick_ms       <= ADDRESS_KICK_RST;
			cfg_q.station_restart_ms    <= STATION_RESTART_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RETRY_INTERVAL:  cfg_q.retry_interval_ms <= wr_data;
				REG_ATTEMPT_TIMEOUT: cfg_q.attempt_timeout_ms <= wr_data;
				REG_FAILS_FALLBACK:  cfg_q.fails_before_fallback <= wr_data[TALLY_W-1:0];
				REG_FALLBACK_KEEP:   cfg_q.fallback_keep_ms <= wr_data;
				REG_ADDRESS_KICK:    cfg_q.address_kick_ms <= wr_data;
				REG_STATION_RESTART: cfg_q.station_restart_ms <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/lrs_engine.sv =====
// Supervisor state and the per-item decision logic.
// Depends on lrs_pkg for command codes, cfg_t and result_t.
module lrs_engine
	import lrs_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [NOW_W-1:0]  now_ms,
	input  logic              has_credentials,
	input  logic              link_up,
	input  logic              ap_running,
	input  logic              ap_has_clients,
	input  cfg_t              cfg,
	output result_t           res
);

	localparam int CW = (TIME_BITS > CFG_DATA_W) ? TIME_BITS : CFG_DATA_W;

	logic                 suspended_q, attempting_q, fas_q;
	logic                 held_q, kicked_q, restarted_q, indicator_q;
	logic [TIME_BITS-1:0] last_q, start_q, due_q, assoc_q;
	logic [TALLY_W-1:0]   tally_q;

	logic                 suspended_n, attempting_n, fas_n;
	logic                 held_n, kicked_n, restarted_n, indicator_n;
	logic [TIME_BITS-1:0] last_n, start_n, due_n, assoc_n;
	logic [TALLY_W-1:0]   tally_n;

	logic [TIME_BITS-1:0] now_t, rearm, since, run_time, idle_time, past_due;
	logic [TALLY_W-1:0]   tally_inc;
	logic                 stuck, kick_fire, sta_fire, timed_out;
	logic                 p_begin, p_kick, p_sta, p_start, p_stop;

	assign now_t     = TIME_BITS'(now_ms);
	assign rearm     = now_t + TIME_BITS'(cfg.fallback_keep_ms);
	assign since     = now_t - assoc_q;
	assign run_time  = now_t - start_q;
	assign idle_time = now_t - last_q;
	assign past_due  = now_t - due_q;
	assign tally_inc = (tally_q == TALLY_MAX) ? TALLY_MAX : tally_q + 1'b1;

	// Recovery acts only on an association seen during this attempt.
	assign stuck     = (assoc_q != '0) && (assoc_q >= start_q) && !held_q;
	assign kick_fire = !kicked_q && stuck && (CW'(since) > CW'(cfg.address_kick_ms));
	assign sta_fire  = (kicked_q || kick_fire) && !restarted_q && stuck
		&& (CW'(since) > CW'(cfg.station_restart_ms));
	assign timed_out = CW'(run_time) > CW'(cfg.attempt_timeout_ms);

	always_comb begin
		suspended_n  = suspended_q;
		attempting_n = attempting_q;
		fas_n        = fas_q;
		held_n       = held_q;
		kicked_n     = kicked_q;
		restarted_n  = restarted_q;
		indicator_n  = indicator_q;
		last_n       = last_q;
		start_n      = start_q;
		due_n        = due_q;
		assoc_n      = assoc_q;
		tally_n      = tally_q;
		p_begin      = 1'b0;
		p_kick       = 1'b0;
		p_sta        = 1'b0;
		p_start      = 1'b0;
		p_stop       = 1'b0;
		unique case (cmd)
			CMD_POLL: begin
				if (!suspended_q) begin
					priority if (!has_credentials) begin
						attempting_n = 1'b0;
						indicator_n  = 1'b0;
						tally_n      = '0;
						due_n        = '0;
					end else if (link_up) begin
						attempting_n = 1'b0;
						indicator_n  = 1'b0;
						tally_n      = '0;
						if (fas_q && ap_running) begin
							if (due_q == '0) begin
								due_n = rearm;
							end else if (!past_due[TIME_BITS-1]) begin
								if (!ap_has_clients) begin
									p_stop = 1'b1;
									fas_n  = 1'b0;
									due_n  = '0;
								end else begin
									due_n = rearm;
								end
							end
						end else begin
							due_n = '0;
						end
					end else if (attempting_q) begin
						due_n = '0;
						if (kick_fire) begin
							kicked_n = 1'b1;
							p_kick   = 1'b1;
						end
						if (sta_fire) begin
							restarted_n = 1'b1;
							p_sta       = 1'b1;
						end
						if (timed_out) begin
							attempting_n = 1'b0;
							indicator_n  = 1'b0;
							tally_n      = tally_inc;
							if (tally_inc >= cfg.fails_before_fallback && !ap_running) begin
								p_start = 1'b1;
								fas_n   = 1'b1;
							end
						end
					end else begin
						due_n = '0;
						if (CW'(idle_time) >= CW'(cfg.retry_interval_ms)) begin
							last_n       = now_t;
							start_n      = now_t;
							attempting_n = 1'b1;
							indicator_n  = 1'b1;
							kicked_n     = 1'b0;
							restarted_n  = 1'b0;
							p_begin      = 1'b1;
						end
					end
				end
			end
			CMD_SUSPEND_ON: begin
				suspended_n  = 1'b1;
				attempting_n = 1'b0;
				indicator_n  = 1'b0;
				tally_n      = '0;
				due_n        = '0;
			end
			CMD_SUSPEND_OFF: suspended_n = 1'b0;
			CMD_ASSOCIATED: begin
				assoc_n = now_t;
				held_n  = 1'b0;
			end
			CMD_ADDR_GOT:   held_n = 1'b1;
			CMD_DISCONNECT: held_n = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suspended_q  <= 1'b0;
			attempting_q <= 1'b0;
			fas_q        <= 1'b0;
			held_q       <= 1'b0;
			kicked_q     <= 1'b0;
			restarted_q  <= 1'b0;
			indicator_q  <= 1'b0;
			last_q       <= '0;
			start_q      <= '0;
			due_q        <= '0;
			assoc_q      <= '0;
			tally_q      <= '0;
		end else if (go) begin
			suspended_q  <= suspended_n;
			attempting_q <= attempting_n;
			fas_q        <= fas_n;
			held_q       <= held_n;
			kicked_q     <= kicked_n;
			restarted_q  <= restarted_n;
			indicator_q  <= indicator_n;
			last_q       <= last_n;
			start_q      <= start_n;
			due_q        <= due_n;
			assoc_q      <= assoc_n;
			tally_q      <= tally_n;
		end
	end

	always_comb begin
		res.begin_attempt   = p_begin;
		res.restart_address = p_kick;
		res.restart_station = p_sta;
		res.start_fallback  = p_start;
		res.stop_fallback   = p_stop;
		res.indicator_on    = indicator_n;
		res.attempt_active  = attempting_n;
		res.failure_count   = tally_n;
	end

endmodule

// ===== hw/rtl/link_reconnect_supervisor.sv =====
// Link reconnect supervisor: top level with input register, decision engine and result register.
// An accepted item sits in the input register until the result register can take its result.
// Throughput: one item per cycle unless out_ready stalls; one item can wait in the input stage.
// Configuration writes are registered; cfg_ready is always high.
// Reset clears all supervisor state and loads the register defaults.
// Depends on lrs_pkg, lrs_cfg_regs and lrs_engine.
module link_reconnect_supervisor
	import lrs_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [NOW_W-1:0]      now_ms,
	input  logic                  has_credentials,
	input  logic                  link_up,
	input  logic                  ap_running,
	input  logic                  ap_has_clients,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  begin_attempt,
	output logic                  restart_address,
	output logic                  restart_station,
	output logic                  start_fallback,
	output logic                  stop_fallback,
	output logic                  indicator_on,
	output logic                  attempt_active,
	output logic [TALLY_W-1:0]    failure_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;

	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [NOW_W-1:0]    now_s1;
	logic                creds_s1, link_s1, ap_s1, clients_s1;
	logic                out_valid_q;
	logic                advance, go, take;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign go        = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign take      = in_valid && in_ready;

	lrs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	lrs_engine #(.TIME_BITS(TIME_BITS)) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.go              (go),
		.cmd             (cmd_s1),
		.now_ms          (now_s1),
		.has_credentials (creds_s1),
		.link_up         (link_s1),
		.ap_running      (ap_s1),
		.ap_has_clients  (clients_s1),
		.cfg             (cfg),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) out_valid_q <= valid_s1;
		end
	end

	// Payload registers: load only on a handshake, hold otherwise.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1     <= cmd;
			now_s1     <= now_ms;
			creds_s1   <= has_credentials;
			link_s1    <= link_up;
			ap_s1      <= ap_running;
			clients_s1 <= ap_has_clients;
		end
		if (go) res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign begin_attempt   = res_q.begin_attempt;
	assign restart_address = res_q.restart_address;
	assign restart_station = res_q.restart_station;
	assign start_fallback  = res_q.start_fallback;
	assign stop_fallback   = res_q.stop_fallback;
	assign indicator_on    = res_q.indicator_on;
	assign attempt_active  = res_q.attempt_active;
	assign failure_count   = res_q.failure_count;

endmodule

// ===== dv/link_reconnect_supervisor_test.sv =====
// Self-checking testbench for link_reconnect_supervisor: directed polls and events, then
// random item streams under several register settings, with input bursts and output stalls.
// Depends on lrs_pkg and the link_reconnect_supervisor RTL.
module link_reconnect_supervisor_test;
	import lrs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_LIMIT = 5000;

	// Predicts the supervisor decisions and holds the results still owed by the block.
	class supervisor_scoreboard;
		logic [31:0] retry_ms, timeout_ms, keep_ms, kick_ms, restart_ms;
		logic [7:0] fails_needed;
		bit susp, trying, fb_auto, addr_held, addr_kicked, sta_restarted, busy_led;
		logic [31:0] last_try, try_start, fb_due, assoc_at;
		logic [7:0] tally;
		result_t due_results[$];
		int errors;
		int n_checked;

		function new();
			retry_ms = RETRY_INTERVAL_RST;
			timeout_ms = ATTEMPT_TIMEOUT_RST;
			fails_needed = FAILS_FALLBACK_RST;
			keep_ms = FALLBACK_KEEP_RST;
			kick_ms = ADDRESS_KICK_RST;
			restart_ms = STATION_RESTART_RST;
			susp = 0; trying = 0; fb_auto = 0; addr_held = 0;
			addr_kicked = 0; sta_restarted = 0; busy_led = 0;
			last_try = '0; try_start = '0; fb_due = '0; assoc_at = '0;
			tally = '0;
			errors = 0;
			n_checked = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_RETRY_INTERVAL:  retry_ms = data;
				REG_ATTEMPT_TIMEOUT: timeout_ms = data;
				REG_FAILS_FALLBACK:  fails_needed = data[7:0];
				REG_FALLBACK_KEEP:   keep_ms = data;
				REG_ADDRESS_KICK:    kick_ms = data;
				REG_STATION_RESTART: restart_ms = data;
				default: ;
			endcase
		endfunction

		function void drop_attempt();
			trying = 0;
			busy_led = 0;
		endfunction

		function void decide_poll(logic [31:0] now, bit creds, bit link, bit ap, bit cli,
			inout result_t r);
			logic [31:0] since;
			logic [31:0] age;
			bit stuck;
			if (susp)
				return;
			if (!creds) begin
				drop_attempt();
				tally = '0;
				fb_due = '0;
				return;
			end
			if (link) begin
				drop_attempt();
				tally = '0;
				if (fb_auto && ap) begin
					since = now - fb_due;
					if (fb_due == '0) begin
						// a sum of zero leaves the window unarmed
						fb_due = now + keep_ms;
					end else if (!since[31]) begin
						if (!cli) begin
							r.stop_fallback = 1'b1;
							fb_auto = 0;
							fb_due = '0;
						end else begin
							fb_due = now + keep_ms;
						end
					end
				end else begin
					fb_due = '0;
				end
				return;
			end
			fb_due = '0;
			if (trying) begin
				stuck = assoc_at != '0 && assoc_at >= try_start && !addr_held;
				since = now - assoc_at;
				if (!addr_kicked && stuck && since > kick_ms) begin
					addr_kicked = 1;
					r.restart_address = 1'b1;
				end
				if (addr_kicked && !sta_restarted && stuck && since > restart_ms) begin
					sta_restarted = 1;
					r.restart_station = 1'b1;
				end
				age = now - try_start;
				if (age > timeout_ms) begin
					drop_attempt();
					if (tally != TALLY_MAX)
						tally++;
					if (tally >= fails_needed && !ap) begin
						r.start_fallback = 1'b1;
						fb_auto = 1;
					end
				end
				return;
			end
			age = now - last_try;
			if (age < retry_ms)
				return;
			last_try = now;
			try_start = now;
			trying = 1;
			busy_led = 1;
			addr_kicked = 0;
			sta_restarted = 0;
			r.begin_attempt = 1'b1;
		endfunction

		function void note_input(logic [CMD_W-1:0] c, logic [NOW_W-1:0] now, bit creds,
			bit link, bit ap, bit cli);
			result_t r;
			r = '0;
			case (c)
				CMD_POLL: decide_poll(now, creds, link, ap, cli, r);
				CMD_SUSPEND_ON: begin
					susp = 1;
					drop_attempt();
					tally = '0;
					fb_due = '0;
				end
				CMD_SUSPEND_OFF: susp = 0;
				CMD_ASSOCIATED: begin
					assoc_at = now;
					addr_held = 0;
				end
				CMD_ADDR_GOT: addr_held = 1;
				CMD_DISCONNECT: addr_held = 0;
				default: ;
			endcase
			r.indicator_on = busy_led;
			r.attempt_active = trying;
			r.failure_count = tally;
			due_results.push_back(r);
		endfunction

		function void compare(string field, logic [7:0] exp_v, logic [7:0] got_v);
			if (exp_v !== got_v) begin
				errors++;
				$display("%0t: %s expected %0d actual %0d", $time, field, exp_v, got_v);
			end
		endfunction

		function void check_result(result_t got);
			result_t e;
			n_checked++;
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, actual %h", $time, got);
				return;
			end
			e = due_results.pop_front();
			compare("begin_attempt", e.begin_attempt, got.begin_attempt);
			compare("restart_address", e.restart_address, got.restart_address);
			compare("restart_station", e.restart_station, got.restart_station);
			compare("start_fallback", e.start_fallback, got.start_fallback);
			compare("stop_fallback", e.stop_fallback, got.stop_fallback);
			compare("indicator_on", e.indicator_on, got.indicator_on);
			compare("attempt_active", e.attempt_active, got.attempt_active);
			compare("failure_count", e.failure_count, got.failure_count);
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CMD_W-1:0] cmd = CMD_POLL;
	logic [NOW_W-1:0] now_ms = '0;
	logic has_credentials = 1'b0;
	logic link_up = 1'b0;
	logic ap_running = 1'b0;
	logic ap_has_clients = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic begin_attempt, restart_address, restart_station, start_fallback, stop_fallback;
	logic indicator_on, attempt_active;
	logic [TALLY_W-1:0] failure_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	supervisor_scoreboard board = new();

	// world seen by the random stream
	logic [31:0] clock_ms;
	logic [31:0] step_lo, step_hi;
	bit link_w, ap_w;

	link_reconnect_supervisor dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("link_reconnect_supervisor: mismatch");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result({begin_attempt, restart_address, restart_station, start_fallback,
				stop_fallback, indicator_on, attempt_active, failure_count});
	end

	// Receiver: random stall modes, plus one long hold-off to back up the input side.
	initial begin : receiver
		int mode;
		int left;
		int k;
		bit held;
		bit rdy;
		mode = 0;
		left = 0;
		k = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (!held && board.n_checked >= HOLD_AFTER) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			k++;
			case (mode)
				0: rdy = 1'b1;
				1: rdy = $urandom_range(0, 1);
				2: rdy = (k % 5) != 0;
				default: rdy = $urandom_range(0, 3) == 0;
			endcase
			out_ready <= rdy;
		end
	end

	task automatic send_item(logic [CMD_W-1:0] c, logic [NOW_W-1:0] now, bit cr, bit lk,
		bit ap, bit cl);
		cmd <= c;
		now_ms <= now;
		has_credentials <= cr;
		link_up <= lk;
		ap_running <= ap;
		ap_has_clients <= cl;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_input(c, now, cr, lk, ap, cl);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
	endtask

	// Hold input until every owed result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_regs(logic [31:0] retry, logic [31:0] timeout, logic [31:0] fails,
		logic [31:0] keep, logic [31:0] kick, logic [31:0] restart, bit poke_unused);
		drain();
		if (poke_unused) begin
			cfg_write(REG_UNUSED_6, $urandom);
			cfg_write(REG_UNUSED_7, 32'hFFFF_FFFF);
		end
		cfg_write(REG_RETRY_INTERVAL, retry);
		cfg_write(REG_ATTEMPT_TIMEOUT, timeout);
		cfg_write(REG_FAILS_FALLBACK, fails);
		cfg_write(REG_FALLBACK_KEEP, keep);
		cfg_write(REG_ADDRESS_KICK, kick);
		cfg_write(REG_STATION_RESTART, restart);
		cfg_valid <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic next_item(bit sat);
		int r;
		logic [CMD_W-1:0] c;
		logic [NOW_W-1:0] now;
		bit cr, lk, ap, cl;
		r = $urandom_range(0, 99);
		if (sat)
			c = r < 92 ? CMD_POLL : r < 95 ? CMD_ASSOCIATED : r < 97 ? CMD_ADDR_GOT :
				r < 99 ? CMD_DISCONNECT : CMD_UNUSED_7;
		else
			c = r < 60 ? CMD_POLL : r < 70 ? CMD_ASSOCIATED : r < 77 ? CMD_ADDR_GOT :
				r < 84 ? CMD_DISCONNECT : r < 87 ? CMD_SUSPEND_ON :
				r < 95 ? CMD_SUSPEND_OFF : r < 97 ? CMD_UNUSED_6 : CMD_UNUSED_7;
		clock_ms = clock_ms + $urandom_range(step_lo, step_hi);
		now = clock_ms;
		if (!sat && $urandom_range(0, 24) == 0)
			now = $urandom;
		if ($urandom_range(0, 11) == 0)
			link_w = !link_w;
		if ($urandom_range(0, 6) == 0)
			ap_w = !ap_w;
		cr = $urandom_range(0, 19) != 0;
		lk = link_w;
		ap = ap_w;
		cl = $urandom_range(0, 2) == 0;
		if (c != CMD_POLL) begin
			// flags are ignored off a poll: toggle them freely
			cr = $urandom_range(0, 1);
			lk = $urandom_range(0, 1);
			ap = $urandom_range(0, 1);
			cl = $urandom_range(0, 1);
		end
		if (sat) begin
			cr = 1;
			lk = 0;
		end
		send_item(c, now, cr, lk, ap, cl);
	endtask

	task automatic run_random(int count, logic [31:0] lo, logic [31:0] hi, logic [31:0] base,
		bit sat);
		int burst;
		int gap;
		step_lo = lo;
		step_hi = hi;
		clock_ms = base;
		burst = $urandom_range(1, 40);
		repeat (count) begin
			next_item(sat);
			burst--;
			if (burst == 0) begin
				gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 40);
			end
		end
	endtask

	initial begin : stimulus
		int waited;
		link_w = 0;
		ap_w = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults in force
		send_item(CMD_POLL, 32'd0, 1, 0, 0, 0);
		send_item(CMD_UNUSED_6, 32'hFFFF_FFFF, 1, 1, 1, 1);
		send_item(CMD_UNUSED_7, 32'hAAAA_AAAA, 0, 0, 0, 0);
		send_item(CMD_ASSOCIATED, 32'd0, 1, 0, 0, 0);    // association at time zero
		send_item(CMD_POLL, 32'd5000, 1, 0, 0, 0);
		send_item(CMD_POLL, 32'd30000, 1, 0, 0, 0);
		send_item(CMD_POLL, 32'd40000, 1, 0, 0, 0);
		send_item(CMD_ASSOCIATED, 32'd39000, 1, 0, 0, 0); // earlier than attempt start
		send_item(CMD_POLL, 32'd58000, 1, 0, 0, 0);
		send_item(CMD_POLL, 32'd60001, 1, 0, 0, 0);
		send_item(CMD_POLL, 32'd70000, 1, 0, 0, 0);
		send_item(CMD_ASSOCIATED, 32'd70001, 1, 0, 0, 0);
		// both recovery steps, timeout and fallback start in one poll
		send_item(CMD_POLL, 32'd90001, 1, 0, 0, 0);
		// window arming sum wraps to zero, then arms on the next poll
		send_item(CMD_POLL, 32'hFFFF_15A0, 1, 1, 1, 0);
		send_item(CMD_POLL, 32'hFFFF_15AA, 1, 1, 1, 0);
		send_item(CMD_POLL, 32'd5, 1, 1, 1, 0);
		send_item(CMD_POLL, 32'd10, 1, 1, 1, 1);
		send_item(CMD_POLL, 32'd60010, 1, 1, 1, 0);
		send_item(CMD_SUSPEND_ON, 32'd60020, 1, 0, 0, 0);
		send_item(CMD_POLL, 32'd70000, 1, 0, 0, 0);
		send_item(CMD_SUSPEND_OFF, 32'd70001, 0, 1, 0, 1);
		send_item(CMD_ADDR_GOT, 32'd70002, 1, 0, 1, 0);
		send_item(CMD_DISCONNECT, 32'd70003, 0, 0, 0, 0);
		send_item(CMD_POLL, 32'd80000, 0, 0, 0, 0);
		send_item(CMD_POLL, 32'hFFFF_FFFF, 1, 0, 0, 0);

		// short timers, clock crossing the top bit
		load_regs(32'd50, 32'd200, 32'd2, 32'd100, 32'd30, 32'd80, 0);
		run_random(300, 32'd0, 32'd60, 32'h7FFF_FF00, 0);
		// failures pile up until the count saturates; threshold of zero, upper data bits set
		load_regs(32'd1, 32'd1, 32'hABCD_EF00, 32'd1, 32'd1, 32'd2, 0);
		run_random(560, 32'd1, 32'd4, $urandom, 1);
		// largest values everywhere, unused register indexes poked
		load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_56FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1);
		run_random(100, 32'd0, 32'hFFFF_FFFF, $urandom, 0);
		// clock wrapping through zero
		load_regs(32'd20, 32'd500, 32'd1, 32'd40, 32'd100, 32'd150, 0);
		run_random(250, 32'd0, 32'd40, 32'hFFFF_FF00, 0);
		load_regs(RETRY_INTERVAL_RST, ATTEMPT_TIMEOUT_RST, 32'(FAILS_FALLBACK_RST),
			FALLBACK_KEEP_RST, ADDRESS_KICK_RST, STATION_RESTART_RST, 0);
		run_random(100, 32'd0, 32'd3000, 32'd0, 0);

		in_valid <= 1'b0;
		waited = 0;
		while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (board.pending() != 0) begin
			board.errors++;
			$display("%0t: %0d results never arrived", $time, board.pending());
		end
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("link_reconnect_supervisor: match");
		else
			$display("link_reconnect_supervisor: mismatch");
		$finish;
	end

endmodule
